[design/indexed_insert_remove_list_defines.svh]
// Assertion macros shared by the list engine.
`ifndef INDEXED_INSERT_REMOVE_LIST_DEFINES_SVH
`define INDEXED_INSERT_REMOVE_LIST_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IIRL_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("list engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IIRL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("list engine check failed");

`endif

[design/iirl_pkg.sv]
`default_nettype none

package iirl_pkg;

    localparam int DEPTH   = 16;
    localparam int WIDTH   = 32;

    localparam int CMD_W   = 3;
    localparam int IDX_W   = 8;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ADDR_W  = $clog2(DEPTH);
    // common width for index and count comparisons
    localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int RD_W    = (WIDTH > VAL_W) ? WIDTH : VAL_W;

    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // cell actions broadcast along the chain
    localparam int ACT_W = 3;
    localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FILL   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd5;

    typedef logic [WIDTH-1:0] word_t;
    typedef logic [DEPTH-1:0][WIDTH-1:0] word_row_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [CMP_W-1:0] idx;
        logic [CMP_W-1:0] cnt;
        word_t            value;
    } bcast_t;

endpackage

`default_nettype wire

[design/iirl_cell.sv]
`default_nettype none

// One list slot: decide locally by position whether to hold, load, zero or shift.
module iirl_cell (
    input  wire logic                      aclk,
    input  wire logic [iirl_pkg::CMP_W-1:0] pos,
    input  wire iirl_pkg::bcast_t          bcast,
    input  wire iirl_pkg::word_t           left_word,
    input  wire iirl_pkg::word_t           right_word,
    output iirl_pkg::word_t                word
);

    iirl_pkg::word_t word_reg;
    iirl_pkg::word_t word_next;

    logic [iirl_pkg::CMP_W:0] pos_inc;
    logic [iirl_pkg::CMP_W:0] cnt_ext;

    assign pos_inc = {1'b0, pos} + 1'b1;
    assign cnt_ext = {1'b0, bcast.cnt};

    always_comb begin
        word_next = word_reg;
        unique case (bcast.action)
            iirl_pkg::ACT_APPEND: begin
                if (pos == bcast.cnt) begin
                    word_next = bcast.value;
                end
            end
            iirl_pkg::ACT_INSERT: begin
                if (pos == bcast.idx) begin
                    word_next = bcast.value;
                end else if (pos > bcast.idx && pos <= bcast.cnt) begin
                    word_next = left_word;
                end
            end
            iirl_pkg::ACT_FILL: begin
                if (pos == bcast.idx) begin
                    word_next = bcast.value;
                end else if (pos >= bcast.cnt && pos < bcast.idx) begin
                    word_next = '0;
                end
            end
            iirl_pkg::ACT_REMOVE: begin
                if (pos >= bcast.idx && pos_inc < cnt_ext) begin
                    word_next = right_word;
                end
            end
            iirl_pkg::ACT_WRITE: begin
                if (pos == bcast.idx) begin
                    word_next = bcast.value;
                end
            end
            default: begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

`default_nettype wire

[design/iirl_chain.sv]
`default_nettype none

// Row of list cells; each cell sees its neighbours, and the end cells see zero past the ends.
module iirl_chain (
    input  wire logic                aclk,
    input  wire iirl_pkg::bcast_t    bcast,
    output iirl_pkg::word_row_t      words
);

    iirl_pkg::word_row_t left_w;
    iirl_pkg::word_row_t right_w;

    for (genvar g = 0; g < iirl_pkg::DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign left_w[g] = '0;
        end else begin : g_mid_l
            assign left_w[g] = words[g-1];
        end

        if (g == iirl_pkg::DEPTH - 1) begin : g_last
            assign right_w[g] = '0;
        end else begin : g_mid_r
            assign right_w[g] = words[g+1];
        end

        iirl_cell u_cell (
            .aclk       (aclk),
            .pos        (iirl_pkg::CMP_W'(g)),
            .bcast      (bcast),
            .left_word  (left_w[g]),
            .right_word (right_w[g]),
            .word       (words[g])
        );
    end

endmodule

`default_nettype wire

[design/indexed_insert_remove_list.sv]
// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  s_command[3], s_index[8], s_value[32]
// m_       out        m_valid / m_ready  m_read_value[32], m_count[5], m_status[2]
//
// One transaction is taken per cycle while s_ready is high; its result
// appears in the output register on the next cycle. The rate is set by the
// cell chain, which shifts, loads or holds every slot at once. s_ready is
// high whenever the output register is empty or being emptied, so a stalled
// result holds only the input. aresetn is synchronous and active low: it
// empties the list and the output register; the stored words are not cleared.
`default_nettype none

module indexed_insert_remove_list (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [iirl_pkg::CMD_W-1:0]    s_command,
    input  wire logic [iirl_pkg::IDX_W-1:0]    s_index,
    input  wire logic [iirl_pkg::VAL_W-1:0]    s_value,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [iirl_pkg::VAL_W-1:0]         m_read_value,
    output logic [iirl_pkg::COUNT_W-1:0]       m_count,
    output logic [iirl_pkg::STAT_W-1:0]        m_status
);

`include "indexed_insert_remove_list_defines.svh"

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [iirl_pkg::CNT_W-1:0]   cnt_reg;
    logic [iirl_pkg::CNT_W-1:0]   cnt_next;

    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [iirl_pkg::VAL_W-1:0]   m_read_value_reg;
    logic [iirl_pkg::COUNT_W-1:0] m_count_reg;
    logic [iirl_pkg::STAT_W-1:0]  m_status_reg;

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    logic                          accept;
    logic [iirl_pkg::CMP_W-1:0]    cnt_w;
    logic [iirl_pkg::CMP_W-1:0]    idx_w;
    logic [iirl_pkg::RD_W-1:0]     val_wide;
    logic [iirl_pkg::RD_W-1:0]     rd_wide;
    logic [iirl_pkg::CMP_W-1:0]    cnt_after_w;
    logic [iirl_pkg::ACT_W-1:0]    action;
    logic [iirl_pkg::STAT_W-1:0]   status;
    logic                          do_read;
    logic [iirl_pkg::CNT_W-1:0]    cnt_result;
    iirl_pkg::bcast_t              bcast;
    iirl_pkg::word_row_t           words;

    assign accept   = s_valid && s_ready;
    assign s_ready  = !m_valid_reg || m_ready;

    assign cnt_w    = iirl_pkg::CMP_W'(cnt_reg);
    assign idx_w    = iirl_pkg::CMP_W'(s_index);
    assign val_wide = iirl_pkg::RD_W'(s_value);

    // Decide the action for the chain and the status of this transaction.
    always_comb begin
        action     = iirl_pkg::ACT_NONE;
        status     = iirl_pkg::ST_OK;
        do_read    = 1'b0;
        cnt_result = cnt_reg;
        unique case (s_command)
            iirl_pkg::CMD_APPEND: begin
                if (cnt_w >= iirl_pkg::DEPTH_CMP) begin
                    status = iirl_pkg::ST_FULL;
                end else begin
                    action     = iirl_pkg::ACT_APPEND;
                    cnt_result = cnt_reg + 1'b1;
                end
            end
            iirl_pkg::CMD_INSERT: begin
                if (idx_w < cnt_w) begin
                    if (cnt_w >= iirl_pkg::DEPTH_CMP) begin
                        status = iirl_pkg::ST_FULL;
                    end else begin
                        action     = iirl_pkg::ACT_INSERT;
                        cnt_result = cnt_reg + 1'b1;
                    end
                end else if (idx_w >= iirl_pkg::DEPTH_CMP) begin
                    status = iirl_pkg::ST_FULL;
                end else begin
                    // insert at or past the end: pad the gap with zero words
                    action     = iirl_pkg::ACT_FILL;
                    cnt_result = iirl_pkg::CNT_W'(idx_w + 1'b1);
                end
            end
            iirl_pkg::CMD_REMOVE: begin
                if (idx_w >= cnt_w) begin
                    status = iirl_pkg::ST_RANGE;
                end else begin
                    action     = iirl_pkg::ACT_REMOVE;
                    cnt_result = cnt_reg - 1'b1;
                end
            end
            iirl_pkg::CMD_READ: begin
                if (idx_w >= cnt_w) begin
                    status = iirl_pkg::ST_RANGE;
                end else begin
                    do_read = 1'b1;
                end
            end
            iirl_pkg::CMD_WRITE: begin
                if (idx_w >= cnt_w) begin
                    status = iirl_pkg::ST_RANGE;
                end else begin
                    action = iirl_pkg::ACT_WRITE;
                end
            end
            iirl_pkg::CMD_CLEAR: begin
                cnt_result = '0;
            end
            default: begin
                // unused commands leave everything as it is
                cnt_result = cnt_reg;
            end
        endcase
    end

    // Broadcast to the chain only on an accepted transaction.
    assign bcast.action = accept ? action : iirl_pkg::ACT_NONE;
    assign bcast.idx    = idx_w;
    assign bcast.cnt    = cnt_w;
    assign bcast.value  = val_wide[iirl_pkg::WIDTH-1:0];

    iirl_chain u_chain (
        .aclk  (aclk),
        .bcast (bcast),
        .words (words)
    );

    // Read port: select the addressed cell, zero unless the read is in range.
    assign rd_wide     = do_read ? iirl_pkg::RD_W'(words[s_index[iirl_pkg::ADDR_W-1:0]])
                                 : '0;
    assign cnt_after_w = iirl_pkg::CMP_W'(cnt_result);

    assign cnt_next     = accept ? cnt_result : cnt_reg;
    assign m_valid_next = accept || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the result register on accept; hold it while the consumer stalls.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_read_value_reg <= rd_wide[iirl_pkg::VAL_W-1:0];
            m_count_reg      <= cnt_after_w[iirl_pkg::COUNT_W-1:0];
            m_status_reg     <= status;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_count      = m_count_reg;
    assign m_status     = m_status_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `IIRL_ASSERT_IMPL(a_cnt_bound, aclk, aresetn, 1'b1, cnt_w <= iirl_pkg::DEPTH_CMP)
    `IIRL_ASSERT_NEXT(a_full_holds, aclk, aresetn, accept && status == iirl_pkg::ST_FULL, cnt_reg == $past(cnt_reg))
    `IIRL_ASSERT_IMPL(a_err_zero, aclk, aresetn, m_valid_reg && m_status_reg != iirl_pkg::ST_OK, m_read_value_reg == '0)
    `IIRL_ASSERT_NEXT(a_clear_empty, aclk, aresetn, accept && s_command == iirl_pkg::CMD_CLEAR, cnt_reg == '0 && m_valid_reg)

endmodule

`default_nettype wire

[tb/sv/tb_indexed_insert_remove_list.sv]
`default_nettype none

module tb_indexed_insert_remove_list;
    timeunit 1ns;
    timeprecision 1ps;

    import iirl_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 1325;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    // Codes the block leaves unused; it must treat them as no-ops.
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    // One expected response transaction.
    typedef struct {
        logic [VAL_W-1:0]   read_value;
        logic [COUNT_W-1:0] count;
        logic [STAT_W-1:0]  status;
    } list_result_t;

    // Shadow copy of the list: works out the response of every accepted
    // command and holds those responses until the block delivers them.
    class list_scoreboard;
        word_t        cells [DEPTH];
        int unsigned  fill;
        list_result_t awaited [$];
        int unsigned  errors;

        function new();
            fill   = 0;
            errors = 0;
            foreach (cells[i]) cells[i] = '0;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                   logic [VAL_W-1:0] val);
            list_result_t r;
            int unsigned  pos;
            int           k;
            word_t        word;
            pos          = 32'(idx);
            word         = word_t'(val);
            r.read_value = '0;
            r.status     = ST_OK;
            case (cmd)
                CMD_APPEND: begin
                    if (fill >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        cells[fill] = word;
                        fill++;
                    end
                end
                CMD_INSERT: begin
                    if (pos < fill) begin
                        if (fill >= DEPTH) begin
                            r.status = ST_FULL;
                        end else begin
                            for (k = fill; k > pos; k--) cells[k] = cells[k-1];
                            cells[pos] = word;
                            fill++;
                        end
                    end else if (pos + 1 > DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        // past the end: pad the gap with zero words
                        for (k = fill; k < pos; k++) cells[k] = '0;
                        cells[pos] = word;
                        fill       = pos + 1;
                    end
                end
                CMD_REMOVE: begin
                    if (pos >= fill) begin
                        r.status = ST_RANGE;
                    end else begin
                        for (k = pos; k + 1 < fill; k++) cells[k] = cells[k+1];
                        fill--;
                    end
                end
                CMD_READ: begin
                    if (pos >= fill) r.status = ST_RANGE;
                    else r.read_value = cells[pos];
                end
                CMD_WRITE: begin
                    if (pos >= fill) r.status = ST_RANGE;
                    else cells[pos] = word;
                end
                CMD_CLEAR: begin
                    fill = 0;
                end
                default: begin
                end
            endcase
            r.count = COUNT_W'(fill);
            awaited.push_back(r);
        endfunction

        function void check_result(logic [VAL_W-1:0] rd, logic [COUNT_W-1:0] cnt,
                                   logic [STAT_W-1:0] st);
            list_result_t e;
            if (awaited.size() == 0) begin
                $error("response with no command awaiting it: count %0d status %0d", cnt, st);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (rd !== e.read_value) begin
                $error("read_value: expected 0x%08h, actual 0x%08h", e.read_value, rd);
                errors++;
            end
            if (cnt !== e.count) begin
                $error("count: expected %0d, actual %0d", e.count, cnt);
                errors++;
            end
            if (st !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, st);
                errors++;
            end
        endfunction
    endclass

    // Every input starts at a known value; reset is held from time zero.
    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [CMD_W-1:0]   s_command = CMD_APPEND;
    logic [IDX_W-1:0]   s_index   = '0;
    logic [VAL_W-1:0]   s_value   = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [VAL_W-1:0]   m_read_value;
    logic [COUNT_W-1:0] m_count;
    logic [STAT_W-1:0]  m_status;

    // steady switches idling off on both sides; hold_request asks the
    // receiver for one long hold-off.
    bit steady       = 1'b0;
    bit hold_request = 1'b0;

    list_scoreboard sb = new();

    indexed_insert_remove_list dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_index      (s_index),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_count      (m_count),
        .m_status     (m_status)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Offer one command transaction. Entered and left at a falling edge, so
    // s_valid sees a single assignment per time step. Before offering, idle
    // for a random number of cycles unless the steady stretch is on; once
    // offered, hold valid and payload until the block takes them.
    task send_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                      input logic [VAL_W-1:0] val);
        while (!steady && $urandom_range(0, 99) < 16) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_index   <= idx;
        s_value   <= val;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Sample both channels at the rising edge. Check the response first: it
    // belongs to a command accepted at an earlier edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_read_value, m_count, m_status);
            if (s_valid && s_ready) sb.note_command(s_command, s_index, s_value);
        end
    end

    // Response side: drop ready at random, or for a long counted stretch on
    // request so that the output register stays full and the input stalls.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 16);
            end
        end
    end

    // Watchdog: end the run if it overruns by far.
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int unsigned      roll;
        int unsigned      n;
        int unsigned      pick;
        int unsigned      append_lim;
        int unsigned      insert_lim;
        int unsigned      remove_lim;
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: out-of-range access on an empty list, shifting
        // insert, insert past the end with zero padding, insert at the count,
        // removal at both ends, unused codes, every form of the full case,
        // clear, and a padded insert straight into an empty list.
        send_command(CMD_READ,    8'd0,   32'd0);
        send_command(CMD_REMOVE,  8'd0,   32'd0);
        send_command(CMD_WRITE,   8'd0,   32'hFFFF_FFFF);
        send_command(CMD_APPEND,  8'd0,   32'hFFFF_FFFF);
        send_command(CMD_APPEND,  8'hFF,  32'h0000_0000);
        send_command(CMD_INSERT,  8'd0,   32'hA5A5_A5A5);
        send_command(CMD_READ,    8'd0,   32'd0);
        send_command(CMD_READ,    8'd1,   32'd0);
        send_command(CMD_INSERT,  8'd5,   32'h1234_5678);
        send_command(CMD_READ,    8'd4,   32'd0);
        send_command(CMD_INSERT,  8'd6,   32'h5A5A_5A5A);
        send_command(CMD_REMOVE,  8'd0,   32'd0);
        send_command(CMD_REMOVE,  8'd5,   32'd0);
        send_command(CMD_WRITE,   8'd2,   32'hFFFF_FFFF);
        send_command(CMD_READ,    8'd2,   32'd0);
        send_command(CMD_SPARE_6, 8'hFF,  32'hFFFF_FFFF);
        send_command(CMD_SPARE_7, 8'h80,  32'h8000_0000);
        send_command(CMD_INSERT,  8'd15,  32'h8000_0001);
        send_command(CMD_APPEND,  8'd0,   32'hDEAD_0001);
        send_command(CMD_INSERT,  8'd3,   32'hDEAD_0002);
        send_command(CMD_INSERT,  8'hFF,  32'hDEAD_0003);
        send_command(CMD_READ,    8'd15,  32'd0);
        send_command(CMD_CLEAR,   8'd0,   32'd0);
        send_command(CMD_INSERT,  8'd15,  32'h7FFF_FFFF);
        send_command(CMD_CLEAR,   8'hFF,  32'hFFFF_FFFF);

        // Random part: alternate growing and shrinking phases so the list
        // visits both empty and full, with indices mostly inside the list.
        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            steady = (item >= 500 && item < 800);
            if (item == 250 || item == 1000) hold_request = 1'b1;
            if ((item / 120) % 2 == 0) begin
                append_lim = 25;
                insert_lim = 50;
                remove_lim = 58;
            end else begin
                append_lim = 10;
                insert_lim = 20;
                remove_lim = 50;
            end
            n    = sb.fill;
            val  = $urandom();
            pick = $urandom_range(0, 9);
            if (pick == 0) idx = IDX_W'($urandom_range(0, 255));
            else if (pick == 1) idx = IDX_W'(n + $urandom_range(1, 3));
            else if (pick == 2 || n == 0) idx = IDX_W'(n);
            else idx = IDX_W'($urandom_range(0, n - 1));

            roll = $urandom_range(0, 99);
            if (roll < append_lim) cmd = CMD_APPEND;
            else if (roll < insert_lim) cmd = CMD_INSERT;
            else if (roll < remove_lim) cmd = CMD_REMOVE;
            else if (roll < 74) cmd = CMD_READ;
            else if (roll < 89) cmd = CMD_WRITE;
            else if (roll < 91) cmd = CMD_CLEAR;
            else if (roll < 94) cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
            else begin
                // noise: any code, any index
                cmd = CMD_W'($urandom());
                idx = IDX_W'($urandom_range(0, 255));
            end
            send_command(cmd, idx, val);
        end
        s_valid <= 1'b0;
        steady  = 1'b0;

        // Drain the outstanding responses, then keep watching for any stray transaction.
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
